@@ rtl/ebr_pkg.sv @@
// Package for the edge blend ramp generator: register codes, pipeline sizes,
// the exp2 factor table and the per-stage log/exp step functions.
// No dependencies.
package ebr_pkg;

    typedef enum logic [2:0] {
        CFG_ZONE_WIDTH = 3'd0,
        CFG_MIDPOINT   = 3'd1,
        CFG_EXPONENT   = 3'd2,
        CFG_GAMMA      = 3'd3,
        CFG_FALLING    = 3'd4
    } t_cfg_idx;

    localparam logic [10:0] MAX_ZONE_WIDTH = 11'd1024;
    localparam logic [10:0] RST_ZONE_WIDTH = 11'd256;
    localparam logic [15:0] RST_MIDPOINT   = 16'd32768;
    localparam logic [15:0] RST_EXPONENT   = 16'd8192;
    localparam logic [15:0] RST_GAMMA      = 16'd9011;

    localparam int DIV1_STEPS = 16;
    localparam int LOG_STEPS  = 16;
    localparam int EXP_STEPS  = 16;
    localparam int DIV2_STEPS = 21;
    localparam int LATENCY    = 111;

    localparam logic [15:0] FALL_TOP = 16'd65280;
    localparam logic [16:0] Q_ONE    = 17'h10000;
    localparam logic [20:0] Q_SAT    = 21'h110000;
    localparam logic [30:0] EXP_ONE  = 31'h4000_0000;

    typedef logic [15:0][29:0] t_ctab;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] vv;
        r  = '0;
        b  = 64'h4000_0000_0000_0000;
        vv = v;
        for (int i = 0; i < 32; i++) begin
            if (vv >= r + b) begin
                vv = vv - (r + b);
                r  = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_ctab ctab_init();
        logic [63:0] c;
        t_ctab       t;
        c    = isqrt64(64'd1 << 59);
        t[0] = c[29:0];
        for (int i = 1; i < 16; i++) begin
            c    = isqrt64(c << 30);
            t[i] = c[29:0];
        end
        return t;
    endfunction

    localparam t_ctab CTAB = ctab_init();

    function automatic logic [4:0] lead_one(input logic [16:0] x);
        logic [4:0] e;
        e = '0;
        for (int i = 1; i < 17; i++) begin
            if (x[i]) begin
                e = 5'(i);
            end
        end
        return e;
    endfunction

    function automatic logic [30:0] log_norm(input logic [16:0] x, input logic [4:0] e);
        logic [30:0] t;
        t = {14'd0, x} << (5'd30 - e);
        return t;
    endfunction

    function automatic logic [31:0] log_step(input logic [30:0] m);
        logic [61:0] sq;
        logic [31:0] t;
        sq = {31'd0, m} * {31'd0, m};
        t  = sq[61:30];
        return t[31] ? {1'b1, t[31:1]} : {1'b0, t[30:0]};
    endfunction

    function automatic logic [20:0] log_result(input logic [4:0] e, input logic [15:0] fl);
        logic [4:0] ip;
        ip = 5'd16 - e;
        return {ip, 16'd0} - {5'd0, fl};
    endfunction

    function automatic logic [30:0] exp_step(input logic [30:0] r, input logic [29:0] c,
                                             input logic en);
        logic [60:0] pr;
        pr = {30'd0, r} * {31'd0, c};
        return en ? pr[60:30] : r;
    endfunction

    function automatic logic [16:0] exp_final(input logic [30:0] r, input logic [4:0] ip);
        logic [16:0] t;
        t = r[30:14];
        return t >> ip;
    endfunction

endpackage

@@ rtl/edge_blend_ramp_generator.sv @@
// Edge blend ramp generator top level: position to blend weight in one pipeline.
// Depends on ebr_pkg (scoped names).
//
// channel   signals                                   transfer when
// input     i_start, o_busy, i_position               i_start high, o_busy low
// result    o_valid, o_weight                         o_valid high, one cycle
// config    i_cfg_valid, o_cfg_ready, i_cfg_index,    i_cfg_valid and o_cfg_ready
//           i_cfg_data
//
// One position per clock; each weight is registered in r_weight and leaves with its o_valid.
// The pipeline holds the two 16-step log squarings, the two 16-step exp
// products and the 16- and 21-step radix-2 dividers, one step per stage.
// Synchronous active-low reset clears the valid line and loads the config defaults.
// The result side has no stall: the pipeline advances every cycle.
module edge_blend_ramp_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [9:0]  i_position,
    output logic        o_valid,
    output logic [7:0]  o_weight,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [10:0] r_zone_width;
    logic [15:0] r_midpoint;
    logic [15:0] r_exponent;
    logic [15:0] r_gamma;
    logic        r_falling;

    logic [10:0] w_eff;
    logic [15:0] g_eff;
    logic [9:0]  k_in;

    logic [ebr_pkg::LATENCY-1:0] r_vld;

    // width divider
    logic [10:0] r_d1_rem [0:16];
    logic [15:0] r_d1_q   [0:16];
    logic [10:0] n_d1_rem [1:16];
    logic [15:0] n_d1_q   [1:16];

    // select
    logic [16:0] r_sx;
    logic        r_shi;
    logic [16:0] n_sx;
    logic        n_shi;

    // first log
    logic [30:0] r_la_m  [0:16];
    logic [15:0] r_la_fl [0:16];
    logic [4:0]  r_la_e  [0:16];
    logic        r_la_z  [0:16];
    logic        r_la_hi [0:16];
    logic [30:0] n_la_m  [1:16];
    logic [15:0] n_la_fl [1:16];

    // first exp
    logic [30:0] r_ea_r  [0:16];
    logic [20:0] r_ea_q  [0:16];
    logic        r_ea_z  [0:16];
    logic        r_ea_hi [0:16];
    logic [30:0] n_ea_r  [1:16];
    logic [20:0] n_ea_q0;

    logic [16:0] r_pw;
    logic        r_pw_hi;
    logic [16:0] n_pw;
    logic [16:0] r_b;
    logic [16:0] n_b;

    // second log
    logic [30:0] r_lb_m  [0:16];
    logic [15:0] r_lb_fl [0:16];
    logic [4:0]  r_lb_e  [0:16];
    logic        r_lb_z  [0:16];
    logic [30:0] n_lb_m  [1:16];
    logic [15:0] n_lb_fl [1:16];

    // gamma divider
    logic [15:0] r_d2_rem [0:21];
    logic [20:0] r_d2_lo  [0:21];
    logic [20:0] r_d2_q   [0:21];
    logic        r_d2_sat [0:21];
    logic        r_d2_z   [0:21];
    logic [15:0] n_d2_rem [1:21];
    logic [20:0] n_d2_q   [1:21];
    logic [20:0] n2_b;

    // second exp
    logic [30:0] r_eb_r [0:16];
    logic [20:0] r_eb_q [0:16];
    logic        r_eb_z [0:16];
    logic [30:0] n_eb_r [1:16];
    logic [20:0] n_eb_q0;

    logic [7:0]  r_weight;
    logic [7:0]  n_weight;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_vld[ebr_pkg::LATENCY-1];
    assign o_weight    = r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_width <= ebr_pkg::RST_ZONE_WIDTH;
            r_midpoint   <= ebr_pkg::RST_MIDPOINT;
            r_exponent   <= ebr_pkg::RST_EXPONENT;
            r_gamma      <= ebr_pkg::RST_GAMMA;
            r_falling    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ebr_pkg::t_cfg_idx'(i_cfg_index))
                ebr_pkg::CFG_ZONE_WIDTH: r_zone_width <= i_cfg_data[10:0];
                ebr_pkg::CFG_MIDPOINT:   r_midpoint   <= i_cfg_data;
                ebr_pkg::CFG_EXPONENT:   r_exponent   <= i_cfg_data;
                ebr_pkg::CFG_GAMMA:      r_gamma      <= i_cfg_data;
                ebr_pkg::CFG_FALLING:    r_falling    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ebr_pkg::LATENCY-2:0], i_start && !o_busy};
        end
    end

    always_comb begin
        if (r_zone_width == 11'd0) begin
            w_eff = 11'd1;
        end else if (r_zone_width > ebr_pkg::MAX_ZONE_WIDTH) begin
            w_eff = ebr_pkg::MAX_ZONE_WIDTH;
        end else begin
            w_eff = r_zone_width;
        end
        g_eff = (r_gamma == 16'd0) ? 16'd1 : r_gamma;
        if ({1'b0, i_position} >= w_eff) begin
            k_in = 10'(w_eff - 11'd1);
        end else begin
            k_in = i_position;
        end
    end

    always_comb begin
        logic [11:0] t;
        for (int s = 0; s < ebr_pkg::DIV1_STEPS; s++) begin
            t = {r_d1_rem[s], 1'b0};
            if (t >= {1'b0, w_eff}) begin
                n_d1_rem[s+1] = 11'(t - {1'b0, w_eff});
                n_d1_q[s+1]   = {r_d1_q[s][14:0], 1'b1};
            end else begin
                n_d1_rem[s+1] = t[10:0];
                n_d1_q[s+1]   = {r_d1_q[s][14:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [15:0] a;
        logic [16:0] d;
        if (r_falling) begin
            a = (r_d1_q[16] > ebr_pkg::FALL_TOP) ? 16'd0 : ebr_pkg::FALL_TOP - r_d1_q[16];
        end else begin
            a = r_d1_q[16];
        end
        n_shi = a[15];
        d     = ebr_pkg::Q_ONE - {1'b0, a};
        n_sx  = n_shi ? {d[15:0], 1'b0} : {a, 1'b0};
    end

    always_comb begin
        logic [31:0] sa;
        logic [31:0] sb;
        for (int s = 0; s < ebr_pkg::LOG_STEPS; s++) begin
            sa = ebr_pkg::log_step(r_la_m[s]);
            n_la_m[s+1]  = sa[30:0];
            n_la_fl[s+1] = {r_la_fl[s][14:0], sa[31]};
            sb = ebr_pkg::log_step(r_lb_m[s]);
            n_lb_m[s+1]  = sb[30:0];
            n_lb_fl[s+1] = {r_lb_fl[s][14:0], sb[31]};
        end
    end

    always_comb begin
        logic [20:0] n;
        logic [36:0] pr;
        n  = ebr_pkg::log_result(r_la_e[16], r_la_fl[16]);
        pr = {16'd0, n} * {21'd0, r_exponent};
        n_ea_q0 = (pr[36:12] >= {4'd0, ebr_pkg::Q_SAT}) ? ebr_pkg::Q_SAT : pr[32:12];
    end

    always_comb begin
        for (int i = 1; i <= ebr_pkg::EXP_STEPS; i++) begin
            n_ea_r[i] = ebr_pkg::exp_step(r_ea_r[i-1], ebr_pkg::CTAB[i-1],
                                          r_ea_q[i-1][16-i]);
            n_eb_r[i] = ebr_pkg::exp_step(r_eb_r[i-1], ebr_pkg::CTAB[i-1],
                                          r_eb_q[i-1][16-i]);
        end
    end

    always_comb begin
        if (r_ea_z[16]) begin
            n_pw = (r_exponent == 16'd0) ? ebr_pkg::Q_ONE : 17'd0;
        end else begin
            n_pw = ebr_pkg::exp_final(r_ea_r[16], r_ea_q[16][20:16]);
        end
    end

    always_comb begin
        logic [16:0] ma;
        logic [33:0] pr;
        logic [16:0] t;
        ma  = r_pw_hi ? (ebr_pkg::Q_ONE - {1'b0, r_midpoint}) : {1'b0, r_midpoint};
        pr  = {17'd0, ma} * {17'd0, r_pw};
        t   = pr[32:16];
        n_b = r_pw_hi ? (ebr_pkg::Q_ONE - t) : t;
    end

    assign n2_b = ebr_pkg::log_result(r_lb_e[16], r_lb_fl[16]);

    always_comb begin
        logic [16:0] t;
        for (int s = 0; s < ebr_pkg::DIV2_STEPS; s++) begin
            t = {r_d2_rem[s], r_d2_lo[s][20]};
            if (t >= {1'b0, g_eff}) begin
                n_d2_rem[s+1] = 16'(t - {1'b0, g_eff});
                n_d2_q[s+1]   = {r_d2_q[s][19:0], 1'b1};
            end else begin
                n_d2_rem[s+1] = t[15:0];
                n_d2_q[s+1]   = {r_d2_q[s][19:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_d2_sat[21] || (r_d2_q[21] >= ebr_pkg::Q_SAT)) begin
            n_eb_q0 = ebr_pkg::Q_SAT;
        end else begin
            n_eb_q0 = r_d2_q[21];
        end
    end

    always_comb begin
        logic [16:0] rr;
        rr = ebr_pkg::exp_final(r_eb_r[16], r_eb_q[16][20:16]);
        if (r_eb_z[16]) begin
            n_weight = 8'd0;
        end else if (rr[16]) begin
            n_weight = 8'd255;
        end else begin
            n_weight = rr[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1_rem[0] <= {1'b0, k_in};
        r_d1_q[0]   <= '0;
        for (int s = 1; s <= ebr_pkg::DIV1_STEPS; s++) begin
            r_d1_rem[s] <= n_d1_rem[s];
            r_d1_q[s]   <= n_d1_q[s];
        end

        r_sx  <= n_sx;
        r_shi <= n_shi;

        r_la_e[0]  <= ebr_pkg::lead_one(r_sx);
        r_la_m[0]  <= ebr_pkg::log_norm(r_sx, ebr_pkg::lead_one(r_sx));
        r_la_fl[0] <= '0;
        r_la_z[0]  <= (r_sx == 17'd0);
        r_la_hi[0] <= r_shi;
        for (int s = 1; s <= ebr_pkg::LOG_STEPS; s++) begin
            r_la_m[s]  <= n_la_m[s];
            r_la_fl[s] <= n_la_fl[s];
            r_la_e[s]  <= r_la_e[s-1];
            r_la_z[s]  <= r_la_z[s-1];
            r_la_hi[s] <= r_la_hi[s-1];
        end

        r_ea_r[0]  <= ebr_pkg::EXP_ONE;
        r_ea_q[0]  <= n_ea_q0;
        r_ea_z[0]  <= r_la_z[16];
        r_ea_hi[0] <= r_la_hi[16];
        for (int i = 1; i <= ebr_pkg::EXP_STEPS; i++) begin
            r_ea_r[i]  <= n_ea_r[i];
            r_ea_q[i]  <= r_ea_q[i-1];
            r_ea_z[i]  <= r_ea_z[i-1];
            r_ea_hi[i] <= r_ea_hi[i-1];
        end

        r_pw    <= n_pw;
        r_pw_hi <= r_ea_hi[16];
        r_b     <= n_b;

        r_lb_e[0]  <= ebr_pkg::lead_one(r_b);
        r_lb_m[0]  <= ebr_pkg::log_norm(r_b, ebr_pkg::lead_one(r_b));
        r_lb_fl[0] <= '0;
        r_lb_z[0]  <= (r_b == 17'd0);
        for (int s = 1; s <= ebr_pkg::LOG_STEPS; s++) begin
            r_lb_m[s]  <= n_lb_m[s];
            r_lb_fl[s] <= n_lb_fl[s];
            r_lb_e[s]  <= r_lb_e[s-1];
            r_lb_z[s]  <= r_lb_z[s-1];
        end

        r_d2_rem[0] <= {4'd0, n2_b[20:9]};
        r_d2_lo[0]  <= {n2_b[8:0], 12'd0};
        r_d2_q[0]   <= '0;
        r_d2_sat[0] <= ({4'd0, n2_b[20:9]} >= g_eff);
        r_d2_z[0]   <= r_lb_z[16];
        for (int s = 1; s <= ebr_pkg::DIV2_STEPS; s++) begin
            r_d2_rem[s] <= n_d2_rem[s];
            r_d2_q[s]   <= n_d2_q[s];
            r_d2_lo[s]  <= {r_d2_lo[s-1][19:0], 1'b0};
            r_d2_sat[s] <= r_d2_sat[s-1];
            r_d2_z[s]   <= r_d2_z[s-1];
        end

        r_eb_r[0] <= ebr_pkg::EXP_ONE;
        r_eb_q[0] <= n_eb_q0;
        r_eb_z[0] <= r_d2_z[21];
        for (int i = 1; i <= ebr_pkg::EXP_STEPS; i++) begin
            r_eb_r[i] <= n_eb_r[i];
            r_eb_q[i] <= r_eb_q[i-1];
            r_eb_z[i] <= r_eb_z[i-1];
        end

        r_weight <= n_weight;
    end

endmodule
